### src/jesc_pkg.sv
// ----------------------------------------------------------------------------
// jesc_pkg: shared types and constants of the julia escape-time pixel unit
// fixed-point formats, mapping constants, item types and the color rom
// ----------------------------------------------------------------------------
package jesc_pkg;

  localparam int ITER_BUDGET = 300;
  localparam int FRAC_BITS   = 28;
  localparam int MAX_DIM     = 4096;

  localparam int PIX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int CNT_W  = $clog2(ITER_BUDGET + 1);
  localparam int COL_W  = 8;

  // q4.frac values and their products
  localparam int Q_W    = FRAC_BITS + 4;
  localparam int PROD_W = 2 * Q_W;
  localparam int SQ_W   = 2 * (Q_W - 1) - FRAC_BITS;
  localparam int XM_W   = SQ_W + 2;

  // coordinate division: quotient below the span, span below 2^(frac+2)
  localparam int QUO_W  = FRAC_BITS + 2;
  localparam int DVD_W  = PIX_W + QUO_W;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [63:0] SPAN_X   = ((64'd16 << FRAC_BITS) * 2 + 5) / 10;
  localparam logic [63:0] SPAN_Y   = ((64'd9 << FRAC_BITS) * 2 + 5) / 10;
  localparam logic [63:0] HALF_X   = ((64'd8 << FRAC_BITS) * 2 + 5) / 10;
  localparam logic [63:0] HALF_Y   = ((64'd9 << FRAC_BITS) * 2 + 10) / 20;
  localparam logic [63:0] C_RE_MAG = ((64'd79 << FRAC_BITS) * 2 + 100) / 200;
  localparam logic [63:0] C_IM     = ((64'd3 << FRAC_BITS) * 2 + 20) / 40;
  localparam logic [63:0] ESC_LIM  = 64'd4 << FRAC_BITS;

  localparam logic [63:0] M3 = 64'(ITER_BUDGET) * 64'(ITER_BUDGET) * 64'(ITER_BUDGET);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd320;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] red_value;
    logic [COL_W-1:0] green_value;
    logic [COL_W-1:0] blue_value;
    logic [8:0]       iterations_left;
    logic             status;
  } out_item_t;

  typedef logic [ITER_BUDGET:0][3*COL_W-1:0] color_rom_t;

  function automatic logic [127:0] upow(input logic [127:0] b, input int e);
    logic [127:0] acc;
    acc = 128'd1;
    for (int i = 0; i < e; i++) acc = acc * b;
    return acc;
  endfunction

  // largest k in [0,lim] with k^q * m^p <= lim^q * n^p
  function automatic int scaled_root(input int lim, input int p, input int q,
                                     input int n, input int m);
    logic [127:0] rhs;
    logic [127:0] lhs;
    int lo;
    int hi;
    int mid;
    rhs = upow(128'(lim), q) * upow(128'(n), p);
    lo  = 0;
    hi  = lim;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = upow(128'(mid), q) * upow(128'(m), p);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic color_rom_t build_color_rom();
    color_rom_t  rom;
    int          kr;
    int          kg;
    logic [63:0] n3;
    logic [63:0] blue;
    rom    = '0;
    rom[0] = {8'd200, 8'd100, 8'd100};
    for (int n = 1; n <= ITER_BUDGET; n++) begin
      kr     = scaled_root(500, 8, 5, n, ITER_BUDGET);
      kg     = scaled_root(255, 3, 10, n, ITER_BUDGET);
      n3     = 64'(n) * 64'(n) * 64'(n);
      blue   = (64'd255 * (M3 - n3)) / M3;
      rom[n] = {8'(0 - kr), 8'(0 - kg), blue[7:0]};
    end
    return rom;
  endfunction

  localparam color_rom_t COLOR_ROM = build_color_rom();

endpackage

### src/jesc_if.sv
// ----------------------------------------------------------------------------
// jesc_if: item channels of the julia escape-time pixel unit
// valid/ready channels for pixel coordinates and color results
// ----------------------------------------------------------------------------
interface jesc_in_if
  import jesc_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jesc_out_if
  import jesc_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/julia_escape_time_pixel_unit.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit: escape-time color of one julia-set pixel
// maps a pixel to q4.28, iterates z = z^2 + c on one shared multiplier and
// looks up the color of the remaining iteration budget
// ----------------------------------------------------------------------------
// One pixel is in flight at a time; in_chan is ready only while the unit is
// idle, and a finished result moves to the output register and lets the next
// pixel in, unless that register still holds an item that has not been taken,
// in which case the unit waits for it. A pixel outside the image goes from
// idle straight to S_DONE and skips the mapping and iteration; any other pixel
// is mapped, then iterated until it escapes or spends all 300 iterations, and
// then colored. The unit is idle again, and can accept the next pixel, in the
// same cycle as the result appears in the output register. The two coordinate
// divisions run one quotient bit a cycle (30 quotient bits each), and in every
// iteration the single 32x32 multiplier forms the three products im*im, re*re
// and im*re one after another.
module julia_escape_time_pixel_unit
  import jesc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  jesc_in_if.sink              in_chan,
  jesc_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL_Y = 4'd1;
  localparam logic [3:0] S_DIV_Y = 4'd2;
  localparam logic [3:0] S_MUL_X = 4'd3;
  localparam logic [3:0] S_DIV_X = 4'd4;
  localparam logic [3:0] S_FIX_X = 4'd5;
  localparam logic [3:0] S_IT_A  = 4'd6;
  localparam logic [3:0] S_IT_B  = 4'd7;
  localparam logic [3:0] S_IT_C  = 4'd8;
  localparam logic [3:0] S_IT_D  = 4'd9;
  localparam logic [3:0] S_COLOR = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [3:0]        state_r;
  logic [3:0]        state_nxt;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic              outside;

  logic [PIX_W-1:0]  px_r;
  logic [PIX_W-1:0]  py_r;
  logic              err_r;

  logic [Q_W-1:0]    mul_a;
  logic [Q_W-1:0]    mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] prod_r;

  logic [DIM_W-1:0]  dim_r;
  logic [DIM_W-1:0]  rem_r;
  logic [DIM_W-1:0]  rem_nxt;
  logic [QUO_W-1:0]  quo_r;
  logic [QUO_W-1:0]  quo_nxt;
  logic [STEP_W-1:0] step_r;
  logic [DIM_W:0]    trial;
  logic [DIM_W:0]    diff;
  logic              qbit;
  logic              div_last;

  logic signed [Q_W-1:0] re_r;
  logic signed [Q_W-1:0] im_r;
  logic [Q_W-1:0]        abs_re;
  logic [Q_W-1:0]        abs_im;
  logic [SQ_W-1:0]       ii_r;
  logic [SQ_W-1:0]       rr_r;
  logic [SQ_W:0]         mag_sum;
  logic                  escape;
  logic [XM_W-1:0]       cross_mag;
  logic [XM_W-1:0]       cross_sgn;
  logic [Q_W-1:0]        re_nxt;
  logic [SQ_W+1:0]       im_wide;
  logic [Q_W-1:0]        im_nxt;
  logic [CNT_W-1:0]      left_r;

  logic [3*COL_W-1:0]    color_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  assign w_eff   = (width_r > DIM_MAX) ? DIM_MAX : width_r;
  assign h_eff   = (height_r > DIM_MAX) ? DIM_MAX : height_r;
  assign outside = ({1'b0, in_chan.data.pixel_x} >= w_eff) ||
                   ({1'b0, in_chan.data.pixel_y} >= h_eff);

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  assign abs_re = re_r[Q_W-1] ? Q_W'(-re_r) : Q_W'(re_r);
  assign abs_im = im_r[Q_W-1] ? Q_W'(-im_r) : Q_W'(im_r);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_MUL_Y: begin
        mul_a = Q_W'(py_r);
        mul_b = Q_W'(SPAN_Y);
      end
      S_MUL_X: begin
        mul_a = Q_W'(px_r);
        mul_b = Q_W'(SPAN_X);
      end
      S_IT_A: begin
        mul_a = abs_im;
        mul_b = abs_im;
      end
      S_IT_B: begin
        mul_a = abs_re;
        mul_b = abs_re;
      end
      S_IT_C: begin
        mul_a = abs_im;
        mul_b = abs_re;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // restoring divider step
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign diff     = trial - {1'b0, dim_r};
  assign qbit     = (trial >= {1'b0, dim_r});
  assign rem_nxt  = qbit ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
  assign quo_nxt  = {quo_r[QUO_W-2:0], qbit};
  assign div_last = (step_r == STEP_W'(QUO_W - 1));

  // iteration update
  assign mag_sum   = {1'b0, ii_r} + {1'b0, rr_r};
  assign escape    = (mag_sum >= (SQ_W + 1)'(ESC_LIM));
  assign cross_mag = prod_r[FRAC_BITS - 1 +: XM_W];
  assign cross_sgn = (re_r[Q_W-1] ^ im_r[Q_W-1]) ? XM_W'(-cross_mag) : cross_mag;
  assign re_nxt    = cross_sgn[Q_W-1:0] + Q_W'(C_IM);
  assign im_wide   = {2'b00, ii_r} - {2'b00, rr_r} - (SQ_W + 2)'(C_RE_MAG);
  assign im_nxt    = im_wide[Q_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) state_nxt = outside ? S_DONE : S_MUL_Y;
      end
      S_MUL_Y: state_nxt = S_DIV_Y;
      S_DIV_Y: begin
        if (div_last) state_nxt = S_MUL_X;
      end
      S_MUL_X: state_nxt = S_DIV_X;
      S_DIV_X: begin
        if (div_last) state_nxt = S_FIX_X;
      end
      S_FIX_X: state_nxt = S_IT_A;
      S_IT_A:  state_nxt = (left_r == '0) ? S_COLOR : S_IT_B;
      S_IT_B:  state_nxt = S_IT_C;
      S_IT_C:  state_nxt = S_IT_D;
      S_IT_D:  state_nxt = escape ? S_COLOR : S_IT_A;
      S_COLOR: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_DONE && (!out_valid_r || out_chan.ready)) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          px_r  <= in_chan.data.pixel_x;
          py_r  <= in_chan.data.pixel_y;
          err_r <= outside;
        end
      end
      S_MUL_Y: begin
        rem_r  <= {1'b0, mul_p[DVD_W-1:QUO_W]};
        quo_r  <= mul_p[QUO_W-1:0];
        dim_r  <= h_eff;
        step_r <= '0;
      end
      S_MUL_X: begin
        rem_r  <= {1'b0, mul_p[DVD_W-1:QUO_W]};
        quo_r  <= mul_p[QUO_W-1:0];
        dim_r  <= w_eff;
        step_r <= '0;
        re_r   <= Q_W'(quo_r) - Q_W'(HALF_Y);
      end
      S_DIV_Y, S_DIV_X: begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        step_r <= step_r + STEP_W'(1);
      end
      S_FIX_X: begin
        im_r   <= Q_W'(quo_r) - Q_W'(HALF_X);
        left_r <= CNT_W'(ITER_BUDGET);
      end
      S_IT_A: prod_r <= mul_p;
      S_IT_B: begin
        prod_r <= mul_p;
        ii_r   <= prod_r[FRAC_BITS +: SQ_W];
      end
      S_IT_C: begin
        prod_r <= mul_p;
        rr_r   <= prod_r[FRAC_BITS +: SQ_W];
      end
      S_IT_D: begin
        if (!escape) begin
          re_r   <= re_nxt;
          im_r   <= im_nxt;
          left_r <= left_r - CNT_W'(1);
        end
      end
      S_COLOR: color_r <= COLOR_ROM[left_r];
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          if (err_r) begin
            out_data_r <= {{(3*COL_W+9){1'b0}}, STATUS_ERR};
          end else begin
            out_data_r <= {color_r, 9'(left_r), STATUS_OK};
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input accepted while a pixel was in flight");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.data.status == STATUS_ERR |->
      out_chan.data.red_value == '0 && out_chan.data.green_value == '0 &&
      out_chan.data.blue_value == '0 && out_chan.data.iterations_left == '0)
    else $error("rejected pixel carries nonzero fields");

  a_rem_below_dim: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_Y || state_r == S_DIV_X |-> rem_r < dim_r)
    else $error("divider remainder not below divisor");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == S_FIX_X |-> left_r <= CNT_W'(ITER_BUDGET))
    else $error("iteration budget out of range");
`endif

endmodule
